// ===== src/bcg_pkg.sv =====
// shared types and constants for the button click gesture classifier
package bcg_pkg;

    localparam int NUM_MODES_DEF = 7;

    localparam int CNT_W  = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [CNT_W-1:0] CLICK_WINDOW_RST = 8'd10;
    localparam logic [CNT_W-1:0] LONG_WAIT_RST    = 8'd40;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT    = 8'd1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WINDOW = 2'd1,
        PH_LONG   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } gesture_t;

    typedef struct packed {
        logic [CNT_W-1:0] click_window_ticks;
        logic [CNT_W-1:0] long_wait_ticks;
    } cfg_t;

endpackage

// ===== src/bcg_cfg.sv =====
// configuration registers for the gesture classifier
module bcg_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcg_pkg::CNT_W-1:0]      cfg_data,
    output bcg_pkg::cfg_t                  cfg
);
    import bcg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_CLICK_WINDOW: cfg_next.click_window_ticks = cfg_data;
                CFG_LONG_WAIT:    cfg_next.long_wait_ticks    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_window_ticks <= CLICK_WINDOW_RST;
            cfg_reg.long_wait_ticks    <= LONG_WAIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/bcg_core.sv =====
// per-tick state update and result register of the gesture classifier
module bcg_core #(
    parameter int NUM_MODES = bcg_pkg::NUM_MODES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            level,
    input  bcg_pkg::cfg_t   cfg,
    output logic [1:0]      gesture_event,
    output logic [2:0]      current_mode
);
    import bcg_pkg::*;

    localparam int MW = (NUM_MODES > 2) ? $clog2(NUM_MODES) : 1;
    localparam logic [MW-1:0] MODE_LAST = MW'(NUM_MODES - 1);

    logic             prev_level_reg, prev_level_next;
    logic [1:0]       press_reg, press_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] countdown_reg, countdown_next;
    logic [MW-1:0]    mode_reg, mode_next;
    gesture_t         event_reg, event_next;

    logic       fall;
    logic       loaded;
    logic       expired;
    logic       running;
    logic [1:0] press_edge;

    assign fall    = prev_level_reg & ~level;
    assign loaded  = fall && (press_reg == 2'd0);
    assign expired = (countdown_reg <= CNT_W'(1));
    assign running = (phase_reg != PH_IDLE) && !loaded;

    // press count after the edge, saturating at two
    always_comb begin
        press_edge = press_reg;
        if (fall && press_reg != 2'd2) begin
            press_edge = press_reg + 2'd1;
        end
    end

    always_comb begin
        prev_level_next = level;
        press_next      = press_edge;
        phase_next      = phase_reg;
        countdown_next  = countdown_reg;
        mode_next       = mode_reg;
        if (loaded) begin
            phase_next     = PH_WINDOW;
            countdown_next = cfg.click_window_ticks;
        end
        if (running) begin
            countdown_next = expired ? '0 : countdown_reg - CNT_W'(1);
            if (expired) begin
                case (phase_reg)
                    PH_WINDOW: begin
                        if (press_edge == 2'd2) begin
                            press_next = 2'd0;
                            phase_next = PH_IDLE;
                        end else if (level) begin
                            press_next = 2'd0;
                            phase_next = PH_IDLE;
                            mode_next  = (mode_reg == MODE_LAST) ? '0 : mode_reg + MW'(1);
                        end else begin
                            phase_next     = PH_LONG;
                            countdown_next = cfg.long_wait_ticks;
                        end
                    end
                    default: begin
                        press_next = 2'd0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        event_next = EV_NONE;
        if (running && expired) begin
            case (phase_reg)
                PH_WINDOW: begin
                    if (press_edge == 2'd2) begin
                        event_next = EV_DOUBLE;
                    end else if (level) begin
                        event_next = EV_SINGLE;
                    end
                end
                PH_LONG: begin
                    if (!level && press_edge == 2'd1) begin
                        event_next = EV_LONG;
                    end
                end
                default: event_next = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            press_reg      <= 2'd0;
            phase_reg      <= PH_IDLE;
            countdown_reg  <= '0;
            mode_reg       <= '0;
        end else if (en) begin
            prev_level_reg <= prev_level_next;
            press_reg      <= press_next;
            phase_reg      <= phase_next;
            countdown_reg  <= countdown_next;
            mode_reg       <= mode_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (en) begin
            event_reg <= event_next;
        end
    end

    assign gesture_event = event_reg;
    assign current_mode  = 3'(mode_reg);

    a_idle_no_press : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (press_reg == 2'd0))
        else $error("press counted while idle");

    a_busy_has_press : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (press_reg != 2'd0))
        else $error("window open without a press");

    a_mode_range : assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg <= MODE_LAST)
        else $error("mode index out of range");

    a_long_from_wait : assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(en) && event_reg == EV_LONG) |-> ($past(phase_reg) == PH_LONG))
        else $error("long press outside long wait");

endmodule

// ===== src/button_click_gesture_classifier.sv =====
// Button click gesture classifier, top level.
// s_ channel: one word per scan tick, s_tdata[0] is the button level (0 pressed).
// m_ channel: one result word per input word, s_tdata order kept:
//   m_tdata[1:0] gesture (0 none, 1 single, 2 double, 3 long press),
//   m_tdata[4:2] mode index after the tick.
// cfg channel: index 0 writes click_window_ticks, index 1 long_wait_ticks;
//   cfg_ready is always high, write only while no words are in flight.
// Throughput: one word per cycle while the receiver does not stall; the tick update is
//   a single pass of logic between the input register and the result register.
// The receiver may stall: the result register holds, the input register
//   fills, and s_tready drops only once both are occupied.
// Reset (aresetn low, synchronous): empties both stages, restores the
//   configuration defaults (10 and 40 ticks), button released, mode 0.
module button_click_gesture_classifier #(
    parameter int NUM_MODES = bcg_pkg::NUM_MODES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] button_level
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [1:0] gesture_event, [4:2] current_mode
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcg_pkg::CNT_W-1:0]      cfg_data
);
    import bcg_pkg::*;

    cfg_t       cfg;
    logic       in_vld_reg, in_vld_next;
    logic       in_level_reg;
    logic       out_vld_reg, out_vld_next;
    logic       en;
    logic [1:0] gesture_event;
    logic [2:0] current_mode;

    assign en        = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || en;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (en) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (en) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
    end

    bcg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcg_core #(
        .NUM_MODES (NUM_MODES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .level         (in_level_reg),
        .cfg           (cfg),
        .gesture_event (gesture_event),
        .current_mode  (current_mode)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, current_mode, gesture_event};

endmodule

// ===== dv/button_click_gesture_classifier_checker.sv =====
`timescale 1ns / 1ps
// checker for the gesture classifier: predicts each tick and compares the result words
module button_click_gesture_classifier_checker #(
    parameter int NUM_MODES = bcg_pkg::NUM_MODES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] button_level
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,   // [1:0] gesture_event, [4:2] current_mode
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcg_pkg::CNT_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             pending_ticks
);
    import bcg_pkg::*;

    typedef struct packed {
        gesture_t   gesture;
        logic [2:0] mode;
    } tick_result_t;

    tick_result_t     pending_gestures[$];
    int               mismatches;

    logic [CNT_W-1:0] click_window;
    logic [CNT_W-1:0] long_wait;
    logic             prev_level;
    logic [1:0]       press_count;
    phase_t           phase;
    logic [CNT_W-1:0] countdown;
    int unsigned      mode_idx;

    assign fail_count = mismatches;

    // edge first, then countdown; a count loaded on this tick is not decremented
    function automatic tick_result_t classify_tick(input logic level);
        tick_result_t res;
        gesture_t     ev;
        logic         loaded;
        logic         expired;
        ev     = EV_NONE;
        loaded = 1'b0;
        if (prev_level && !level) begin
            if (press_count == 2'd0) begin
                press_count = 2'd1;
                phase       = PH_WINDOW;
                countdown   = click_window;
                loaded      = 1'b1;
            end else if (press_count < 2'd2) begin
                press_count = press_count + 2'd1;
            end
        end
        prev_level = level;

        if (phase != PH_IDLE && !loaded) begin
            expired   = (countdown <= 1);
            countdown = expired ? '0 : countdown - 1'b1;
            if (expired) begin
                if (phase == PH_WINDOW) begin
                    if (press_count >= 2'd2) begin
                        ev          = EV_DOUBLE;
                        press_count = 2'd0;
                        phase       = PH_IDLE;
                    end else if (level) begin
                        ev          = EV_SINGLE;
                        mode_idx    = (mode_idx + 1 >= NUM_MODES) ? 0 : mode_idx + 1;
                        press_count = 2'd0;
                        phase       = PH_IDLE;
                    end else begin
                        // still held: zero count acts as one like the window
                        phase     = PH_LONG;
                        countdown = long_wait;
                    end
                end else begin
                    if (!level && press_count == 2'd1)
                        ev = EV_LONG;
                    press_count = 2'd0;
                    phase       = PH_IDLE;
                end
            end
        end

        res.gesture = ev;
        res.mode    = mode_idx[2:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        tick_result_t exp_res;
        if (!aresetn) begin
            click_window = CLICK_WINDOW_RST;
            long_wait    = LONG_WAIT_RST;
            prev_level   = 1'b1;
            press_count  = 2'd0;
            phase        = PH_IDLE;
            countdown    = '0;
            mode_idx     = 0;
            mismatches   = 0;
            pending_gestures.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CLICK_WINDOW: click_window = cfg_data;
                    CFG_LONG_WAIT:    long_wait    = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (pending_gestures.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word 0x%02h with no tick pending", $realtime,
                                 m_tdata);
                    mismatches++;
                end else begin
                    exp_res = pending_gestures.pop_front();
                    if (m_tdata[1:0] !== exp_res.gesture || m_tdata[4:2] !== exp_res.mode) begin
                        if (mismatches < 10)
                            $display("%0t: gesture exp %0d got %0d, mode exp %0d got %0d",
                                     $realtime, exp_res.gesture, m_tdata[1:0],
                                     exp_res.mode, m_tdata[4:2]);
                        mismatches++;
                    end
                end
            end

            // result appears only after its tick word has been registered, so compare before push
            if (s_tvalid && s_tready)
                pending_gestures.push_back(classify_tick(s_tdata[0]));
        end
        pending_ticks <= pending_gestures.size();
    end

endmodule

// ===== dv/button_click_gesture_classifier_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the gesture classifier: stimulus, receiver, watchdog and verdict
module button_click_gesture_classifier_tb;
    import bcg_pkg::*;

    localparam int IDLE_LIMIT      = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 8;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    int   fail_count;
    int   pending_ticks;
    int   words_sent;
    int   stall_cycles;
    int   win_eff;
    int   lng_eff;
    logic gaps_on;
    logic hold_off_req;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    button_click_gesture_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    button_click_gesture_classifier_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_ticks (pending_ticks)
    );

    // one tick word, with an occasional gap in front of it
    task automatic send_level(input logic level);
        while (gaps_on && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) send_level(level);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // registers change only once every tick result is out
    task automatic set_config(input int win, input int lng);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_ticks != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(CFG_CLICK_WINDOW, win[CNT_W-1:0]);
        write_reg(CFG_LONG_WAIT, lng[CNT_W-1:0]);
        cfg_valid <= 1'b0;
        win_eff = (win == 0) ? 1 : win;
        lng_eff = (lng == 0) ? 1 : lng;
    endtask

    // one well-formed gesture with random timing, some bounce noise, or a released run
    task automatic run_gesture();
        int kind;
        int a;
        int b;
        int c;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                a = $urandom_range(1, win_eff);
                send_run(1'b0, a);
                send_run(1'b1, win_eff + 2 - a + $urandom_range(0, 3));
            end
            3, 4: begin
                a = $urandom_range(1, 1 + win_eff / 3);
                b = $urandom_range(1, 1 + win_eff / 3);
                c = $urandom_range(1, 1 + win_eff / 3);
                send_run(1'b0, a);
                send_run(1'b1, b);
                send_run(1'b0, c);
                send_run(1'b1, win_eff + 2 + $urandom_range(0, 3));
            end
            5, 6: begin
                // release lands near the end of the long wait, on either side
                a = win_eff + lng_eff + $urandom_range(0, 5) - 2;
                send_run(1'b0, (a < 1) ? 1 : a);
                send_run(1'b1, $urandom_range(1, 4));
            end
            7: begin
                send_run(1'b0, win_eff + 1);
                send_run(1'b1, $urandom_range(1, 2));
                send_run(1'b0, $urandom_range(1, 2));
                send_run(1'b1, lng_eff + 2);
            end
            8: begin
                repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
            end
            default: begin
                send_run(1'b1, $urandom_range(1, 5));
            end
        endcase
    endtask

    task automatic run_phase(input int win, input int lng, input int budget);
        int start;
        set_config(win, lng);
        start = words_sent;
        while (words_sent - start < budget)
            run_gesture();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 16);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        gaps_on      = 1'b0;
        hold_off_req = 1'b0;
        words_sent   = 0;
        stall_cycles = 0;
        win_eff      = CLICK_WINDOW_RST;
        lng_eff      = LONG_WAIT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window: two presses inside it give a double click
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 8);

        set_config(2, 3);
        // released exactly on the expiring tick: single click
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        // held through window and long wait: long press
        send_run(1'b0, 6);
        send_run(1'b1, 1);
        // second press during the long wait cancels the long press
        send_run(1'b0, 3);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);

        gaps_on = 1'b1;
        set_config(10, 40);
        hold_off_req = 1'b1;
        while (words_sent < 100)
            run_gesture();

        gaps_on = 1'b0;
        run_phase(1, 1, 60);
        gaps_on = 1'b1;
        run_phase(0, 0, 30);
        run_phase(255, 255, 100);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_ticks != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
